FILE: rtl/u8s_pkg.sv
// shared types, constants and helpers for the utf-8 stream sanitizer
package u8s_pkg;

    localparam logic [7:0] SUB_CHAR = 8'h3F;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // bytes caused by one accepted input item, in output order
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;  // 0..4; only nonzero counts are pushed
        logic            eot;
    } burst_t;

    typedef struct packed {
        logic valid;  // queue holds at least one burst
        logic full;
    } q_stat_t;

    // multi-byte sequence length from a lead byte's bit pattern, 0 for any other byte
    function automatic logic [2:0] seq_len_of(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & 8'hE0) == 8'hC0) len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
        return len;
    endfunction

endpackage

FILE: rtl/u8s_front.sv
// front end: holds partial sequences and turns each input byte into a burst
module u8s_front
    import u8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,        // input transfer this cycle
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output burst_t     burst,
    output logic       burst_push
);

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      exp_reg, exp_next;

    always_comb
    begin
        logic        is_cont;
        logic        fresh;
        logic [2:0]  pos;
        logic [2:0]  len;
        logic [2:0]  cnt_ext;

        held_next   = held_reg;
        cnt_next    = cnt_reg;
        exp_next    = exp_reg;
        burst.bytes = {4{SUB_CHAR}};
        burst.count = 3'd0;
        burst.eot   = end_of_text;

        is_cont = (in_byte[7:6] == 2'b10);
        cnt_ext = {1'b0, cnt_reg};
        len     = seq_len_of(in_byte);
        fresh   = 1'b1;
        pos     = 3'd0;

        if (cnt_reg != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (cnt_ext + 3'd1 == exp_reg) begin
                    // sequence complete: held bytes then this one
                    for (int k = 0; k < 3; k++) begin
                        if (3'(k) < cnt_ext)
                            burst.bytes[k] = held_reg[k];
                        else
                            burst.bytes[k] = in_byte;
                    end
                    burst.bytes[3] = in_byte;
                    burst.count = cnt_ext + 3'd1;
                    cnt_next    = 2'd0;
                    exp_next    = 3'd0;
                end else if (cnt_reg != 2'd3) begin
                    held_next[cnt_reg] = in_byte;
                    cnt_next = cnt_reg + 2'd1;
                    if (end_of_text)
                        burst.count = cnt_ext + 3'd1;
                end else begin
                    // inconsistent hold, every byte replaced
                    burst.count = 3'd4;
                    cnt_next    = 2'd0;
                    exp_next    = 3'd0;
                end
            end else begin
                // broken sequence: one sub per held byte, then start anew
                pos      = cnt_ext;
                cnt_next = 2'd0;
                exp_next = 3'd0;
            end
        end

        if (fresh) begin
            if (!in_byte[7]) begin
                burst.bytes[pos[1:0]] = in_byte;
                burst.count = pos + 3'd1;
            end else if (len == 3'd0 || end_of_text) begin
                burst.count = pos + 3'd1;
            end else begin
                held_next[0] = in_byte;
                cnt_next     = 2'd1;
                exp_next     = len;
                burst.count  = pos;
            end
        end

        if (end_of_text) begin
            held_next = '0;
            cnt_next  = 2'd0;
            exp_next  = 3'd0;
        end

        burst_push = take && (burst.count != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg <= '0;
            cnt_reg  <= 2'd0;
            exp_reg  <= 3'd0;
        end else if (take) begin
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            exp_reg  <= exp_next;
        end
    end

endmodule

FILE: rtl/u8s_queue.sv
// short burst queue between front and back ends
module u8s_queue
    import u8s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  burst_t  push_data,
    input  logic    pop,
    output burst_t  head,
    output q_stat_t stat
);

    burst_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/u8s_back.sv
// back end: walks the head burst out one byte per transfer
module u8s_back
    import u8s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  burst_t  head,
    input  q_stat_t stat,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output logic [7:0] out_byte,
    output logic    run_last,
    output logic    text_done
);

    logic [1:0] idx_reg, idx_next;
    logic       xfer;

    assign out_valid = stat.valid;
    assign out_byte  = head.bytes[idx_reg];
    assign run_last  = ({1'b0, idx_reg} == head.count - 3'd1);
    assign text_done = run_last && head.eot;
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
            idx_next = 2'd0;
        else if (xfer)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

FILE: rtl/utf8_stream_sanitizer.sv
// top level of the utf-8 stream sanitizer
//
// input channel: in_valid/in_ready carries one text byte (in_byte) and
// end_of_text, which marks the last byte of a string and flushes any held
// partial sequence. output channel: out_valid/out_ready carries sanitized
// bytes with run_last on the last byte caused by an input transfer and
// text_done on the final byte of the string.
// the front end classifies each byte in the cycle it is taken and pushes
// the 1..4 bytes it causes, if any, as one burst into a four-entry queue;
// the back end sends them one per cycle while the receiver is ready. each
// burst is registered in the queue before it is sent. input is taken every
// cycle while the queue has a free entry, so a sustained rate of one byte
// per cycle holds as long as the receiver takes one byte per cycle; output
// bandwidth of the back end (one byte per cycle) bounds the rate on broken
// sequences. when the receiver stalls the current byte holds and the queue
// fills, then in_ready drops. reset clears the held sequence and empties
// the queue; no clearing pass is needed.
module utf8_stream_sanitizer
    import u8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_done
);

    burst_t  burst;
    burst_t  head;
    q_stat_t stat;
    logic    burst_push;
    logic    pop;
    logic    take;

    assign in_ready = !stat.full;
    assign take     = in_valid && in_ready;

    u8s_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .burst       (burst),
        .burst_push  (burst_push)
    );

    u8s_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (burst_push),
        .push_data (burst),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    u8s_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_done (text_done)
    );

endmodule
